// ===== rtl/rgb_3x3_convolution_filter_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef RGB_3X3_CONVOLUTION_FILTER_UNIT_MACROS_SVH
`define RGB_3X3_CONVOLUTION_FILTER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RGBCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rgbcf assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RGBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rgbcf assertion failed");

`endif

// ===== rtl/rgbcf_pkg.sv =====
`default_nettype none
package rgbcf_pkg;

  localparam int DefMaxWidth = 1024;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegKernelSel = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOvrFlags  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDivOvr    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffOvr    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegImgWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegImgHeight = 3'd5;

  localparam logic [11:0] DivOvrReset = 12'd42;
  localparam logic [10:0] WidthReset  = 11'd512;
  localparam logic [15:0] HeightReset = 16'd512;

  localparam int NumKernels = 6;

  typedef logic [23:0] pixel_t;

  localparam logic signed [4:0] KWeights [NumKernels][9] = '{
    '{5'sd3, 5'sd5, 5'sd3, 5'sd5, 5'sd10, 5'sd5, 5'sd3, 5'sd5, 5'sd3},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd1, -5'sd2, -5'sd1, -5'sd2, 5'sd13, -5'sd2, -5'sd1, -5'sd2, -5'sd1},
    '{5'sd1, 5'sd0, -5'sd1, 5'sd1, 5'sd0, -5'sd1, 5'sd1, 5'sd0, -5'sd1},
    '{5'sd1, 5'sd1, 5'sd1, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd1, -5'sd1},
    '{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1}
  };
  localparam logic [11:0] KDiv [NumKernels] = '{12'd42, 12'd16, 12'd1, 12'd6, 12'd6, 12'd9};
  localparam logic [7:0]  KOff [NumKernels] = '{8'd0, 8'd128, 8'd0, 8'd128, 8'd128, 8'd0};

endpackage
`default_nettype wire

// ===== rtl/rgbcf_if.sv =====
`default_nettype none
interface rgbcf_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface rgbcf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbcf_ram.sv =====
`default_nettype none
module rgbcf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rgb_3x3_convolution_filter_unit.sv =====
// RGB 3x3 convolution filter, one pixel beat at a time in raster order.
// pix_in carries a pixel (action 0) or a drain request (action 1); res_out
// carries filtered pixels with frame_end marking the last pixel of a frame.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// writes them only while idle; the block does not enforce it. Row y-1 leaves
// while row y arrives, one column behind; the final column of a row leaves
// two beats. After the last row, drain beats read back the last row one
// pixel each, the final one raising frame_end and restarting.
// Timing: a beat is read from both line stores at acceptance, modified and
// written back in the next cycle. Border pixels then go from StData through
// StEmit1 into the output register. Interior pixels go through a restoring
// divider for each channel, 14 steps in StDiv, then StFin and StEmit1. Beats
// that produce nothing go from StData back to StIdle.
// Reset clears counters, window and registers; line stores need no clearing,
// since unwritten entries never reach an output.
// When the receiver stalls, the result waits in the output register; the next
// beat is still accepted and worked on, and then holds until the slot frees.
module rgb_3x3_convolution_filter_unit #(
  parameter int MaxWidth = rgbcf_pkg::DefMaxWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rgbcf_pix_if.sink                            pix_in,
  rgbcf_res_if.source                          res_out,
  input  wire logic                            cfg_we_i,
  input  wire logic [rgbcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rgbcf_pkg::CfgDataW-1:0] cfg_data_i
);
  import rgbcf_pkg::*;

  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 1);
  localparam int WW = (CW > 11) ? CW : 11;
  localparam int DivSteps = 14;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StData  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StFin   = 3'd3;
  localparam logic [2:0] StEmit1 = 3'd4;
  localparam logic [2:0] StEmit2 = 3'd5;

  // configuration
  logic [2:0]         ksel_q;
  logic [1:0]         ovr_q;
  logic [11:0]        div_ovr_q;
  logic signed [12:0] off_ovr_q;
  logic [10:0]        width_q;
  logic [15:0]        height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q    <= '0;
      ovr_q     <= '0;
      div_ovr_q <= DivOvrReset;
      off_ovr_q <= '0;
      width_q   <= WidthReset;
      height_q  <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKernelSel: ksel_q    <= cfg_data_i[2:0];
        RegOvrFlags:  ovr_q     <= cfg_data_i[1:0];
        RegDivOvr:    div_ovr_q <= cfg_data_i[11:0];
        RegOffOvr:    off_ovr_q <= cfg_data_i[12:0];
        RegImgWidth:  width_q   <= cfg_data_i[10:0];
        RegImgHeight: height_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry and kernel parameters
  logic [WW-1:0]      iw;
  logic [WW-1:0]      eff_w;
  logic [AW-1:0]      wm1;
  logic [15:0]        eff_h;
  logic [2:0]         sel;
  logic [11:0]        dv;
  logic signed [12:0] ofs;

  always_comb begin
    iw = WW'(width_q);
    if (iw < WW'(3)) begin
      eff_w = WW'(3);
    end else if (iw > WW'(MaxWidth)) begin
      eff_w = WW'(MaxWidth);
    end else begin
      eff_w = iw;
    end
    wm1   = AW'(eff_w - WW'(1));
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
    sel   = (ksel_q > 3'd5) ? 3'd0 : ksel_q;
    dv    = KDiv[sel];
    if (ovr_q[0]) begin
      dv = (div_ovr_q == 12'd0) ? 12'd1 : div_ovr_q;
    end
    ofs = ovr_q[1] ? off_ovr_q : $signed({5'd0, KOff[sel]});
  end

  logic [2:0]    state_q, state_d;
  logic [15:0]   row_q;
  logic [AW-1:0] col_q;
  logic [AW-1:0] drn_q;
  logic [AW-1:0] col;
  logic [AW-1:0] drn;
  logic          last_col;

  assign col      = (col_q > wm1) ? wm1 : col_q;
  assign drn      = (drn_q > wm1) ? wm1 : drn_q;
  assign last_col = (col == wm1);

  logic accept;
  assign pix_in.ready = (state_q == StIdle);
  assign accept       = pix_in.valid && pix_in.ready;

  // line stores: older holds row y-2, newer row y-1
  pixel_t old_rd, new_rd;
  pixel_t cur_q;
  logic   act_q, ign_q;
  logic   ram_we;

  assign ram_we = (state_q == StData) && !ign_q && !act_q;

  rgbcf_ram #(.Width(24), .Depth(MaxWidth)) u_older (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col),
    .wdata_i (new_rd),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (old_rd)
  );

  rgbcf_ram #(.Width(24), .Depth(MaxWidth)) u_newer (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col),
    .wdata_i (cur_q),
    .re_i    (accept),
    .raddr_i (pix_in.action ? drn : col),
    .rdata_o (new_rd)
  );

  // latch the beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
      act_q <= pix_in.action;
      ign_q <= pix_in.action ? (row_q < eff_h) : (row_q >= eff_h);
    end
  end

  // weighted sums of the 3x3 window
  pixel_t             nw_q [6];
  pixel_t             win  [9];
  logic signed [15:0] sum  [3];
  logic               conv;

  always_comb begin
    win[0] = nw_q[4]; win[1] = nw_q[5]; win[2] = cur_q;
    win[3] = nw_q[2]; win[4] = nw_q[3]; win[5] = new_rd;
    win[6] = nw_q[0]; win[7] = nw_q[1]; win[8] = old_rd;
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int i = 0; i < 9; i++) begin
        sum[ch] = sum[ch] + 16'(KWeights[sel][i] * $signed({1'b0, win[i][23-8*ch -: 8]}));
      end
    end
  end

  assign conv = (row_q != 16'd1) && (col != AW'(1));

  // divider and result registers
  logic [13:0] quo_q [3];
  logic [11:0] rem_q [3];
  logic        neg_q [3];
  logic [3:0]  step_q;
  pixel_t      res1_q, res2_q;
  logic        fe1_q, has2_q;
  pixel_t      fin;

  always_comb begin
    logic signed [16:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      v = neg_q[ch] ? -$signed({3'd0, quo_q[ch]}) : $signed({3'd0, quo_q[ch]});
      v = v + 17'(ofs);
      if (v < 0) begin
        fin[23-8*ch -: 8] = 8'd0;
      end else if (v > 17'sd255) begin
        fin[23-8*ch -: 8] = 8'd255;
      end else begin
        fin[23-8*ch -: 8] = v[7:0];
      end
    end
  end

  logic slot_free;
  logic out_valid_q;
  assign slot_free = !out_valid_q || res_out.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StData;
      StData: begin
        if (ign_q) begin
          state_d = StIdle;
        end else if (act_q) begin
          state_d = StEmit1;
        end else if (row_q >= 16'd1 && col >= AW'(1)) begin
          state_d = conv ? StDiv : StEmit1;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv:   if (step_q == 4'(DivSteps - 1)) state_d = StFin;
      StFin:   state_d = StEmit1;
      StEmit1: if (slot_free) state_d = has2_q ? StEmit2 : StIdle;
      StEmit2: if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      col_q   <= '0;
      drn_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        nw_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StData && !ign_q) begin
        if (act_q) begin
          // drain: the last one restarts the frame
          if (drn == wm1) begin
            row_q <= '0;
            col_q <= '0;
            drn_q <= '0;
          end else begin
            drn_q <= drn + AW'(1);
          end
        end else begin
          nw_q[0] <= nw_q[1]; nw_q[1] <= old_rd;
          nw_q[2] <= nw_q[3]; nw_q[3] <= new_rd;
          nw_q[4] <= nw_q[5]; nw_q[5] <= cur_q;
          if (last_col) begin
            col_q <= '0;
            row_q <= row_q + 16'd1;
            drn_q <= '0;
          end else begin
            col_q <= col + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StData) begin
      step_q <= '0;
      res2_q <= new_rd;
      if (act_q) begin
        res1_q <= new_rd;
        fe1_q  <= (drn == wm1);
        has2_q <= 1'b0;
      end else begin
        res1_q <= nw_q[3];
        fe1_q  <= 1'b0;
        has2_q <= last_col;
      end
      for (int ch = 0; ch < 3; ch++) begin
        neg_q[ch] <= sum[ch][15];
        quo_q[ch] <= sum[ch][15] ? 14'(-sum[ch]) : sum[ch][13:0];
        rem_q[ch] <= '0;
      end
    end else if (state_q == StDiv) begin
      step_q <= step_q + 4'd1;
      for (int ch = 0; ch < 3; ch++) begin
        if ({rem_q[ch], quo_q[ch][13]} >= {1'b0, dv}) begin
          rem_q[ch] <= 12'({rem_q[ch], quo_q[ch][13]} - {1'b0, dv});
          quo_q[ch] <= {quo_q[ch][12:0], 1'b1};
        end else begin
          rem_q[ch] <= {rem_q[ch][10:0], quo_q[ch][13]};
          quo_q[ch] <= {quo_q[ch][12:0], 1'b0};
        end
      end
    end else if (state_q == StFin) begin
      res1_q <= fin;
    end
  end

  // output register
  pixel_t out_pix_q;
  logic   out_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= (state_q == StEmit1) || (state_q == StEmit2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && state_q == StEmit1) begin
      out_pix_q <= res1_q;
      out_fe_q  <= fe1_q;
    end else if (slot_free && state_q == StEmit2) begin
      out_pix_q <= res2_q;
      out_fe_q  <= 1'b0;
    end
  end

  assign res_out.valid     = out_valid_q;
  assign res_out.red_out   = out_pix_q[23:16];
  assign res_out.green_out = out_pix_q[15:8];
  assign res_out.blue_out  = out_pix_q[7:0];
  assign res_out.frame_end = out_fe_q;
endmodule
`default_nettype wire

// ===== rtl/rgbcf_chk.sv =====
`default_nettype none
`include "rgb_3x3_convolution_filter_unit_macros.svh"
module rgbcf_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic       out_fe
);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // one beat in work at a time
  `RGBCF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready)
  // a result never appears the cycle right after acceptance
  `RGBCF_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_acc, !$rose(out_valid))
  `RGBCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `RGBCF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready,
                     $stable(out_red) && $stable(out_fe))
endmodule

bind rgb_3x3_convolution_filter_unit rgbcf_chk u_rgbcf_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_red   (res_out.red_out),
  .out_fe    (res_out.frame_end)
);
`default_nettype wire
